// File: design/ttw_pkg.sv
package ttw_pkg;

	// default screen geometry
	localparam int DEF_COLUMNS = 80;
	localparam int DEF_ROWS    = 25;

	// fixed field widths
	localparam int COL_W   = 7;
	localparam int ROW_W   = 5;
	localparam int COLOR_W = 4;
	localparam int CELL_W  = 16;
	localparam int ADDR_W  = 11;

	// commands
	localparam logic CMD_PUT  = 1'b0;
	localparam logic CMD_READ = 1'b1;

	// control bytes
	localparam logic [7:0] CH_BACKSPACE = 8'h08;
	localparam logic [7:0] CH_NEWLINE   = 8'h0A;
	localparam logic [7:0] CH_RETURN    = 8'h0D;
	localparam logic [7:0] CH_ESCAPE    = 8'h1B;
	localparam logic [7:0] CH_DIGIT_0   = 8'h30;
	localparam logic [7:0] CH_DIGIT_9   = 8'h39;

	// escape color classes
	localparam logic [7:0] CLS_FG        = 8'h33;
	localparam logic [7:0] CLS_BG        = 8'h34;
	localparam logic [7:0] CLS_BG_BRIGHT = 8'h37;
	localparam logic [7:0] CLS_FG_BRIGHT = 8'h39;

	// escape sequence position
	localparam logic [2:0] ESC_IDLE  = 3'd0;
	localparam logic [2:0] ESC_OPEN  = 3'd1;
	localparam logic [2:0] ESC_CLASS = 3'd2;
	localparam logic [2:0] ESC_DIGIT = 3'd3;
	localparam logic [2:0] ESC_LAST  = 3'd4;

	localparam logic [COLOR_W-1:0] FG_RESET = 4'hF;
	localparam logic [COLOR_W-1:0] BG_RESET = 4'h0;
	localparam logic [CELL_W-1:0]  CELL_RESET = 16'h0F00;

	typedef struct packed {
		logic              command;
		logic [7:0]        data_byte;
		logic [ADDR_W-1:0] cell_address;
	} ttw_req_t;

	typedef struct packed {
		logic [CELL_W-1:0]  cell_value;
		logic [COL_W-1:0]   cursor_col;
		logic [ROW_W-1:0]   cursor_row;
		logic [COLOR_W-1:0] fore_color;
		logic [COLOR_W-1:0] back_color;
	} ttw_rsp_t;

	function automatic logic [COLOR_W-1:0] normal_color(input logic [2:0] d);
		logic [COLOR_W-1:0] c;
		case (d)
			3'd0: c = 4'd0;
			3'd1: c = 4'd4;
			3'd2: c = 4'd2;
			3'd3: c = 4'd14;
			3'd4: c = 4'd1;
			3'd5: c = 4'd5;
			3'd6: c = 4'd3;
			default: c = 4'd7;
		endcase
		return c;
	endfunction

	function automatic logic [COLOR_W-1:0] bright_color(input logic [2:0] d);
		logic [COLOR_W-1:0] c;
		case (d)
			3'd0: c = 4'd8;
			3'd1: c = 4'd12;
			3'd2: c = 4'd10;
			3'd3: c = 4'd14;
			3'd4: c = 4'd9;
			3'd5: c = 4'd13;
			3'd6: c = 4'd11;
			default: c = 4'd15;
		endcase
		return c;
	endfunction

endpackage

// File: design/ttw_stream_if.sv
interface ttw_stream_if #(parameter type payload_t = logic);
	logic     valid;
	logic     ready;
	payload_t payload;

	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface

// File: design/text_terminal_writer_core.sv
// Text terminal writer: a COLUMNS x ROWS screen of 16-bit cells (attribute in the
// high byte, character in the low byte) held in one single-port-write memory with
// a registered read. A put item is accepted in the idle state, then executed and
// written in the execute state; a read item issues its memory read at accept and
// has its result in the execute cycle. A put that scrolls adds a sweep of the
// whole memory, one entry per cycle, moving each row up and zeroing the bottom row,
// limited by the one write port, and the finish state then hands the result to
// the output register. After reset the block writes 0x0F00 to every cell before
// request.ready rises. Every item gives exactly one result item; a finished result
// waits in an output register, and the next item is accepted while it waits, then
// holds in a finish cycle until the output register drains.
module text_terminal_writer_core #(
	parameter int COLUMNS = ttw_pkg::DEF_COLUMNS,
	parameter int ROWS    = ttw_pkg::DEF_ROWS
) (
	input  logic        clk,
	input  logic        arst_n,
	ttw_stream_if.sink   request,
	ttw_stream_if.source response
);

	localparam int CELLS      = COLUMNS * ROWS;
	localparam int AW         = $clog2(CELLS);
	localparam int MOVE_CELLS = COLUMNS * (ROWS - 1);

	localparam logic [AW-1:0] LAST_CELL = AW'(CELLS - 1);
	localparam logic [AW-1:0] COLS_A    = AW'(COLUMNS);

	// sequencer states
	localparam logic [2:0] ST_INIT   = 3'd0;
	localparam logic [2:0] ST_IDLE   = 3'd1;
	localparam logic [2:0] ST_EXEC   = 3'd2;
	localparam logic [2:0] ST_SCROLL = 3'd3;
	localparam logic [2:0] ST_FINISH = 3'd4;

	logic [2:0] state_q;
	logic [AW-1:0] sweep_q;

	// cursor, colors and escape tracking
	logic [ttw_pkg::COL_W-1:0]   col_q;
	logic [ttw_pkg::ROW_W-1:0]   row_q;
	logic [ttw_pkg::COLOR_W-1:0] fg_q;
	logic [ttw_pkg::COLOR_W-1:0] bg_q;
	logic [2:0]                  esc_q;
	logic [7:0]                  cls_q;

	// accepted item
	logic       cmd_q;
	logic [7:0] byte_q;
	logic       rd_ok_q;

	logic [ttw_pkg::CELL_W-1:0] value_q;

	// scroll write stage
	logic          mv_valid_s1;
	logic [AW-1:0] mv_addr_s1;
	logic          mv_zero_s1;

	// output register
	logic              out_valid_q;
	ttw_pkg::ttw_rsp_t out_q;
	logic              out_free;
	logic              out_load;

	// screen memory
	logic [ttw_pkg::CELL_W-1:0] ram [CELLS];
	logic [ttw_pkg::CELL_W-1:0] ram_rd_q;
	logic                       ram_we;
	logic [AW-1:0]              ram_wa;
	logic [ttw_pkg::CELL_W-1:0] ram_wd;
	logic [AW-1:0]              ram_ra;

	// execute-stage next values
	logic [ttw_pkg::COL_W:0]     col_n;
	logic [ttw_pkg::ROW_W:0]     row_n;
	logic [ttw_pkg::COLOR_W-1:0] fg_n;
	logic [ttw_pkg::COLOR_W-1:0] bg_n;
	logic [2:0]                  esc_n;
	logic [7:0]                  cls_n;
	logic                        char_put;
	logic                        exec_write;
	logic                        scroll_d;
	logic [ttw_pkg::CELL_W-1:0]  value_d;
	logic [7:0]                  digit;
	logic                        digit_ok;
	logic [AW-1:0]               put_addr;
	logic [AW:0]                 move_src;
	logic                        sweep_zero;
	logic                        accept;

	assign accept        = request.valid && request.ready;
	assign request.ready = (state_q == ST_IDLE);
	assign out_free      = !out_valid_q || response.ready;
	assign response.valid   = out_valid_q;
	assign response.payload = out_q;

	// a finished item enters the output register
	assign out_load = out_free &&
		(((state_q == ST_EXEC) && !scroll_d) || (state_q == ST_FINISH));

	// put position and scroll source address
	assign put_addr   = AW'(row_q) * COLS_A + AW'(col_q);
	assign move_src   = (AW+1)'(sweep_q) + (AW+1)'(COLUMNS);
	assign sweep_zero = (32'(sweep_q) >= MOVE_CELLS);

	// escape color digit
	assign digit    = byte_q - ttw_pkg::CH_DIGIT_0;
	assign digit_ok = (byte_q >= ttw_pkg::CH_DIGIT_0) && (byte_q <= ttw_pkg::CH_DIGIT_9);

	// execute: control bytes, escape sequence, character write, wrap and scroll
	always_comb begin
		col_n    = {1'b0, col_q};
		row_n    = {1'b0, row_q};
		fg_n     = fg_q;
		bg_n     = bg_q;
		esc_n    = esc_q;
		cls_n    = cls_q;
		char_put = 1'b0;
		scroll_d = 1'b0;
		value_d  = '0;
		if (cmd_q == ttw_pkg::CMD_READ) begin
			if (rd_ok_q) begin
				value_d = ram_rd_q;
			end
		end else if (esc_q != ttw_pkg::ESC_IDLE) begin
			// inside a sequence: never printed, never a control
			if (esc_q == ttw_pkg::ESC_CLASS) begin
				cls_n = byte_q;
			end
			if (esc_q == ttw_pkg::ESC_DIGIT && digit_ok) begin
				case (cls_q)
					ttw_pkg::CLS_FG: begin
						if (!digit[3]) begin
							fg_n = ttw_pkg::normal_color(digit[2:0]);
						end else if (digit[3:0] == 4'd9) begin
							fg_n = 4'd15;
						end
					end
					ttw_pkg::CLS_FG_BRIGHT: begin
						if (!digit[3]) begin
							fg_n = ttw_pkg::bright_color(digit[2:0]);
						end
					end
					ttw_pkg::CLS_BG: begin
						if (!digit[3]) begin
							bg_n = ttw_pkg::normal_color(digit[2:0]);
						end
					end
					ttw_pkg::CLS_BG_BRIGHT: begin
						if (!digit[3]) begin
							bg_n = ttw_pkg::bright_color(digit[2:0]);
						end
					end
					default: begin
					end
				endcase
			end
			esc_n = (esc_q >= ttw_pkg::ESC_LAST) ? ttw_pkg::ESC_IDLE : esc_q + 3'd1;
		end else begin
			case (byte_q)
				ttw_pkg::CH_NEWLINE: begin
					row_n = row_n + 1'b1;
				end
				ttw_pkg::CH_RETURN: begin
					col_n = '0;
				end
				ttw_pkg::CH_BACKSPACE: begin
					if (col_n != '0) begin
						col_n = col_n - 1'b1;
					end
				end
				ttw_pkg::CH_ESCAPE: begin
					esc_n = ttw_pkg::ESC_OPEN;
				end
				default: begin
					char_put = 1'b1;
					col_n    = col_n + 1'b1;
				end
			endcase
			if (32'(col_n) >= COLUMNS) begin
				col_n = '0;
				row_n = row_n + 1'b1;
			end
			if (32'(row_n) >= ROWS) begin
				scroll_d = 1'b1;
				row_n    = (ttw_pkg::ROW_W+1)'(ROWS - 1);
			end
		end
	end

	assign exec_write = (state_q == ST_EXEC) && char_put;

	// memory port selection
	always_comb begin
		ram_we = 1'b0;
		ram_wa = sweep_q;
		ram_wd = ttw_pkg::CELL_RESET;
		if (state_q == ST_INIT) begin
			ram_we = 1'b1;
		end else if (mv_valid_s1) begin
			ram_we = 1'b1;
			ram_wa = mv_addr_s1;
			ram_wd = mv_zero_s1 ? '0 : ram_rd_q;
		end else if (exec_write) begin
			ram_we = 1'b1;
			ram_wa = put_addr;
			ram_wd = {bg_q, fg_q, byte_q};
		end
	end

	// a read item is looked up while it is accepted
	always_comb begin
		if (state_q == ST_SCROLL) begin
			ram_ra = sweep_zero ? '0 : move_src[AW-1:0];
		end else begin
			ram_ra = AW'(request.payload.cell_address);
		end
	end

	always_ff @(posedge clk) begin
		if (ram_we) begin
			ram[ram_wa] <= ram_wd;
		end
		ram_rd_q <= ram[ram_ra];
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_INIT;
			sweep_q     <= '0;
			mv_valid_s1 <= 1'b0;
			out_valid_q <= 1'b0;
			col_q       <= '0;
			row_q       <= '0;
			fg_q        <= ttw_pkg::FG_RESET;
			bg_q        <= ttw_pkg::BG_RESET;
			esc_q       <= ttw_pkg::ESC_IDLE;
			cls_q       <= '0;
		end else begin
			mv_valid_s1 <= (state_q == ST_SCROLL);
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (response.ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_INIT: begin
					if (sweep_q == LAST_CELL) begin
						sweep_q <= '0;
						state_q <= ST_IDLE;
					end else begin
						sweep_q <= sweep_q + 1'b1;
					end
				end
				ST_IDLE: begin
					if (accept) begin
						state_q <= ST_EXEC;
					end
				end
				ST_EXEC: begin
					col_q <= col_n[ttw_pkg::COL_W-1:0];
					row_q <= row_n[ttw_pkg::ROW_W-1:0];
					fg_q  <= fg_n;
					bg_q  <= bg_n;
					esc_q <= esc_n;
					cls_q <= cls_n;
					if (scroll_d) begin
						state_q <= ST_SCROLL;
					end else if (out_free) begin
						state_q <= ST_IDLE;
					end else begin
						state_q <= ST_FINISH;
					end
				end
				ST_SCROLL: begin
					if (sweep_q == LAST_CELL) begin
						sweep_q <= '0;
						state_q <= ST_FINISH;
					end else begin
						sweep_q <= sweep_q + 1'b1;
					end
				end
				ST_FINISH: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_q   <= request.payload.command;
			byte_q  <= request.payload.data_byte;
			rd_ok_q <= (32'(request.payload.cell_address) < CELLS);
		end
		mv_addr_s1 <= sweep_q;
		mv_zero_s1 <= sweep_zero;
		if (state_q == ST_EXEC) begin
			value_q <= value_d;
			if (!scroll_d && out_free) begin
				out_q.cell_value <= value_d;
				out_q.cursor_col <= col_n[ttw_pkg::COL_W-1:0];
				out_q.cursor_row <= row_n[ttw_pkg::ROW_W-1:0];
				out_q.fore_color <= fg_n;
				out_q.back_color <= bg_n;
			end
		end else if (state_q == ST_FINISH && out_free) begin
			out_q.cell_value <= value_q;
			out_q.cursor_col <= col_q;
			out_q.cursor_row <= row_q;
			out_q.fore_color <= fg_q;
			out_q.back_color <= bg_q;
		end
	end

	// cursor never leaves the screen
	a_cursor_range: assert property (@(posedge clk) disable iff (!arst_n)
		(32'(col_q) < COLUMNS) && (32'(row_q) < ROWS))
		else $error("cursor outside the screen");

	// escape position stays within a five-byte sequence
	a_esc_range: assert property (@(posedge clk) disable iff (!arst_n)
		esc_q <= ttw_pkg::ESC_LAST)
		else $error("escape position out of range");

	// an accepted item is executed in the next cycle
	a_accept_exec: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> state_q == ST_EXEC)
		else $error("accepted item not executed");

	// scroll writes and character writes never compete for the port
	a_write_port: assert property (@(posedge clk) disable iff (!arst_n)
		!(exec_write && mv_valid_s1))
		else $error("write port conflict");

	// a scrolling put leaves the cursor on the bottom row
	a_scroll_row: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_EXEC && scroll_d) |=> 32'(row_q) == ROWS - 1)
		else $error("scroll left cursor off the bottom row");

endmodule
